### sv/pspc_pkg.sv
// ----------------------------------------------------------------------------
// pspc_pkg
// Shared types, character codes and prefix tables for the PostScript page
// comment counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pspc_pkg;

   // Line length limit and derived widths
   localparam int unsigned LINE_MAX_BYTES = 4096;
   localparam int unsigned LINE_POS_W     = 13;
   localparam logic [LINE_POS_W-1:0] LINE_LAST = LINE_POS_W'(LINE_MAX_BYTES - 1);

   localparam logic [15:0] SAT16 = 16'hFFFF;

   // Character codes
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_R      = 8'h52;

   // Prefix strings, left aligned in 32 bytes (first character in the top byte)
   localparam logic [255:0] LIT_BRACKET  = {"(%%[Page:", {23{8'h00}}};
   localparam logic [255:0] LIT_HEADER   = {"%%Page:", {25{8'h00}}};
   localparam logic [255:0] LIT_REQUIRE  = {"%%Requirements: numcopies(", {6{8'h00}}};
   localparam logic [255:0] LIT_NONPPD   = "%%BeginNonPPDFeature: NumCopies ";

   localparam logic [5:0] LEN_BRACKET = 6'd9;
   localparam logic [5:0] LEN_HEADER  = 6'd7;
   localparam logic [5:0] LEN_REQUIRE = 6'd26;
   localparam logic [5:0] LEN_NONPPD  = 6'd32;

   // Match phase, one-hot
   typedef enum logic [16:0] {
      PH_START  = 17'h00001,
      PH_PCT    = 17'h00002,
      PH_PCT2   = 17'h00004,
      PH_LIT1   = 17'h00008,
      PH_LIT2   = 17'h00010,
      PH_LIT3   = 17'h00020,
      PH_LIT4   = 17'h00040,
      PH_NUM1   = 17'h00080,
      PH_TAIL_A = 17'h00100,
      PH_TAIL_B = 17'h00200,
      PH_TAIL_C = 17'h00400,
      PH_SP2    = 17'h00800,
      PH_NUM3   = 17'h01000,
      PH_WS4    = 17'h02000,
      PH_SIGN4  = 17'h04000,
      PH_NUM4   = 17'h08000,
      PH_IDLE   = 17'h10000
   } phase_type;

   // Totals handed from the parser at the end of a job
   typedef struct packed {
      logic [15:0] page;
      logic [15:0] copies;
   } result_type;

   // Byte of a prefix at a given index
   function automatic logic [7:0] lit_byte(input logic [255:0] s, input logic [4:0] idx);
      logic [255:0] sh;
      sh = s << {idx, 3'b000};
      return sh[255:248];
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // acc * 10 + digit, saturating at 65535
   function automatic logic [15:0] sat_acc(input logic [15:0] acc, input logic [7:0] b);
      logic [19:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, b[3:0]};
      return (v > {4'h0, SAT16}) ? SAT16 : v[15:0];
   endfunction

endpackage

`default_nettype wire

### sv/pspc_parser.sv
// ----------------------------------------------------------------------------
// pspc_parser
// Per-byte line matcher: tracks the line position and match phase, collects
// decimal numbers and keeps the page, header and copy counts.
// ----------------------------------------------------------------------------
`default_nettype none

module pspc_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  end_of_job,
   output pspc_pkg::result_type       result
);
   import pspc_pkg::*;

   logic [LINE_POS_W-1:0] pos_ff, pos_in;
   phase_type             phase_ff, phase_in;
   logic [15:0]           acc_ff, acc_in;
   logic                  dig_ff, dig_in;
   logic                  neg_ff, neg_in;
   logic [15:0]           page_ff, page_in;
   logic [15:0]           hdr_ff, hdr_in;
   logic [15:0]           copies_ff, copies_in;

   logic [255:0]          lit_str;
   logic [5:0]            lit_len;
   phase_type             lit_next;
   logic                  lit_hit;
   logic                  lit_last;
   logic [15:0]           acc_step;
   logic [15:0]           hdr_step;
   logic                  is_ws;

   // Prefix selected by the current literal phase
   always_comb begin
      case (phase_ff)
         PH_LIT2: begin
            lit_str  = LIT_HEADER;
            lit_len  = LEN_HEADER;
            lit_next = PH_SP2;
         end
         PH_LIT3: begin
            lit_str  = LIT_REQUIRE;
            lit_len  = LEN_REQUIRE;
            lit_next = PH_NUM3;
         end
         PH_LIT4: begin
            lit_str  = LIT_NONPPD;
            lit_len  = LEN_NONPPD;
            lit_next = PH_WS4;
         end
         default: begin
            lit_str  = LIT_BRACKET;
            lit_len  = LEN_BRACKET;
            lit_next = PH_NUM1;
         end
      endcase
   end

   assign lit_hit  = (pos_ff < LINE_POS_W'(lit_len)) &&
                     (lit_byte(lit_str, pos_ff[4:0]) == data_byte);
   assign lit_last = (pos_ff + LINE_POS_W'(1)) == LINE_POS_W'(lit_len);
   assign acc_step = sat_acc(acc_ff, data_byte);
   assign hdr_step = (hdr_ff < SAT16) ? hdr_ff + 16'd1 : hdr_ff;
   assign is_ws    = (data_byte == CH_SPACE) ||
                     ((data_byte >= CH_TAB) && (data_byte <= CH_CR));

   // Byte consumption, then line end, then end of job
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      dig_in    = dig_ff;
      neg_in    = neg_ff;
      page_in   = page_ff;
      hdr_in    = hdr_ff;
      copies_in = copies_ff;

      case (phase_ff)
         PH_START: begin
            if (data_byte == CH_LPAREN)   phase_in = PH_LIT1;
            else if (data_byte == CH_PCT) phase_in = PH_PCT;
            else                          phase_in = PH_IDLE;
         end
         PH_PCT: begin
            phase_in = (data_byte == CH_PCT) ? PH_PCT2 : PH_IDLE;
         end
         PH_PCT2: begin
            if (data_byte == CH_P)      phase_in = PH_LIT2;
            else if (data_byte == CH_R) phase_in = PH_LIT3;
            else if (data_byte == CH_B) phase_in = PH_LIT4;
            else                        phase_in = PH_IDLE;
         end
         PH_LIT1, PH_LIT2, PH_LIT3, PH_LIT4: begin
            if (!lit_hit) begin
               phase_in = PH_IDLE;
            end else if (lit_last) begin
               phase_in = lit_next;
               acc_in   = 16'd0;
               dig_in   = 1'b0;
               neg_in   = 1'b0;
               // NumCopies with no digits yields zero copies
               if (phase_ff == PH_LIT4) copies_in = 16'd0;
            end
         end
         PH_NUM1: begin
            if (is_digit(data_byte)) begin
               acc_in = acc_step;
               dig_in = 1'b1;
            end else if (data_byte == CH_SPACE && !dig_ff) begin
               phase_in = PH_NUM1;
            end else if (data_byte == CH_RBRACK && dig_ff) begin
               phase_in = PH_TAIL_A;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_TAIL_A: begin
            phase_in = (data_byte == CH_PCT) ? PH_TAIL_B : PH_IDLE;
         end
         PH_TAIL_B: begin
            phase_in = (data_byte == CH_PCT) ? PH_TAIL_C : PH_IDLE;
         end
         PH_TAIL_C: begin
            if (data_byte == CH_RPAREN && acc_ff > page_ff) page_in = acc_ff;
            phase_in = PH_IDLE;
         end
         PH_SP2: begin
            if (data_byte != CH_SPACE) begin
               if (is_digit(data_byte)) begin
                  hdr_in = hdr_step;
                  if (hdr_step > page_ff) page_in = hdr_step;
               end
               phase_in = PH_IDLE;
            end
         end
         PH_NUM3: begin
            if (is_digit(data_byte)) begin
               acc_in = acc_step;
               dig_in = 1'b1;
            end else begin
               if (data_byte == CH_RPAREN && dig_ff && acc_ff > copies_ff)
                  copies_in = acc_ff;
               phase_in = PH_IDLE;
            end
         end
         PH_WS4, PH_SIGN4, PH_NUM4: begin
            if (phase_ff == PH_WS4 && is_ws) begin
               phase_in = PH_WS4;
            end else if (phase_ff == PH_WS4 && data_byte == CH_PLUS) begin
               phase_in = PH_SIGN4;
            end else if (phase_ff == PH_WS4 && data_byte == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN4;
            end else if (is_digit(data_byte)) begin
               // copy count follows the number digit by digit
               acc_in    = acc_step;
               dig_in    = 1'b1;
               copies_in = neg_ff ? 16'd0 : acc_step;
               phase_in  = PH_NUM4;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Line end: newline or length limit
      if (data_byte == CH_NL || pos_ff >= LINE_LAST) begin
         pos_in   = '0;
         phase_in = PH_START;
         acc_in   = 16'd0;
         dig_in   = 1'b0;
         neg_in   = 1'b0;
      end else begin
         pos_in = pos_ff + LINE_POS_W'(1);
      end

      // Totals for this byte, before the end-of-job clear
      result.page   = page_in;
      result.copies = copies_in;

      if (end_of_job) begin
         pos_in    = '0;
         phase_in  = PH_START;
         acc_in    = 16'd0;
         dig_in    = 1'b0;
         neg_in    = 1'b0;
         page_in   = 16'd0;
         hdr_in    = 16'd0;
         copies_in = 16'd1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_START;
         acc_ff    <= 16'd0;
         dig_ff    <= 1'b0;
         neg_ff    <= 1'b0;
         page_ff   <= 16'd0;
         hdr_ff    <= 16'd0;
         copies_ff <= 16'd1;
      end else if (step) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         dig_ff    <= dig_in;
         neg_ff    <= neg_in;
         page_ff   <= page_in;
         hdr_ff    <= hdr_in;
         copies_ff <= copies_in;
      end
   end

endmodule

`default_nettype wire

### sv/postscript_page_comment_counter_top.sv
// ----------------------------------------------------------------------------
// postscript_page_comment_counter_top
// Counts pages and copies from the comment lines of a PostScript job stream.
// ----------------------------------------------------------------------------
// Usage:
//   The job is sent one byte per transfer on the req_ channel (valid/ready);
//   req_end_of_job marks the last byte. Lines end at a newline or at
//   LINE_MAX_BYTES bytes and are matched against the page and copy comments.
//   After the flagged byte, one result appears on the rsp_ channel: page
//   count, copy count and their 32-bit product. Other bytes give no result.
//   Throughput: one byte per cycle, set by the parse step that follows the
//   input register. After the last byte is transferred, the result passes
//   through the input register, the parse into the result register and
//   the product register before rsp_valid rises.
//   When rsp_ready is low the result is held; ordinary bytes keep flowing,
//   and a further end-of-job byte waits in the input register until the
//   result stage frees. After the result the counts return to their reset
//   values (pages 0, copies 1) for the next job.
//   Reset is synchronous, active high, and empties all stages.
// ----------------------------------------------------------------------------
`default_nettype none

module postscript_page_comment_counter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_job,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_page_count,
   output logic [15:0]      rsp_copy_count,
   output logic [31:0]      rsp_total_pages
);
   import pspc_pkg::*;

   logic        s1_v_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_eoj_ff;
   logic        r1_v_ff;
   result_type  r1_ff;
   logic        out_v_ff;
   logic [15:0] out_page_ff;
   logic [15:0] out_copy_ff;
   logic [31:0] out_total_ff;

   logic        out_adv;
   logic        r1_free;
   logic        s1_fire;
   result_type  parse_result;

   // Stage flow control
   assign out_adv   = !out_v_ff || rsp_ready;
   assign r1_free   = !r1_v_ff || out_adv;
   assign s1_fire   = s1_v_ff && (!s1_eoj_ff || r1_free);
   assign req_ready = !s1_v_ff || s1_fire;

   pspc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_fire),
      .data_byte  (s1_byte_ff),
      .end_of_job (s1_eoj_ff),
      .result     (parse_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_v_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_v_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_eoj_ff  <= req_end_of_job;
      end
   end

   // Result register: totals at the end of a job
   always_ff @(posedge clock) begin
      if (reset) begin
         r1_v_ff <= 1'b0;
      end else if (s1_fire && s1_eoj_ff) begin
         r1_v_ff <= 1'b1;
      end else if (out_adv) begin
         r1_v_ff <= 1'b0;
      end
      if (s1_fire && s1_eoj_ff) r1_ff <= parse_result;
   end

   // Output register with the product
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_adv) begin
         out_v_ff <= r1_v_ff;
      end
      if (out_adv && r1_v_ff) begin
         out_page_ff  <= r1_ff.page;
         out_copy_ff  <= r1_ff.copies;
         out_total_ff <= r1_ff.page * r1_ff.copies;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_page_count  = out_page_ff;
   assign rsp_copy_count  = out_copy_ff;
   assign rsp_total_pages = out_total_ff;

   // Checks
   a_eoj_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_eoj_ff && r1_v_ff && out_v_ff && !rsp_ready) |-> !s1_fire)
      else $error("end-of-job byte parsed while result stages full");

   a_r1_moves: assert property (@(posedge clock) disable iff (reset)
      (r1_v_ff && out_adv) |=> out_v_ff)
      else $error("result lost between result and output registers");

   a_product: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_total_ff == out_page_ff * out_copy_ff))
      else $error("total pages does not match page and copy counts");

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_v_ff && s1_eoj_ff))
      else $error("input stalled without a waiting end-of-job byte");

endmodule

`default_nettype wire
